[hw/rtl/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// Request modes, result status codes, controller states and register indexes.
// No dependencies.
package fbpa_pkg;

  typedef enum logic [1:0] {
    MODE_SETUP    = 2'd0,
    MODE_ALLOC    = 2'd1,
    MODE_FREE     = 2'd2,
    MODE_TEARDOWN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_POOL = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SWEEP
  } state_t;

  localparam logic CFG_BLOCK_SIZE   = 1'b0;
  localparam logic CFG_TOTAL_BLOCKS = 1'b1;

  localparam int BLOCK_SIZE_W   = 16;
  localparam int TOTAL_BLOCKS_W = 9;
  localparam int INDEX_W        = 8;
  localparam int OFFSET_W       = 24;

  localparam logic [BLOCK_SIZE_W-1:0]   BLOCK_SIZE_RST   = 16'd16;
  localparam logic [TOTAL_BLOCKS_W-1:0] TOTAL_BLOCKS_RST = 9'd256;

endpackage

[hw/rtl/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the free-list link table. No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator kept as a LIFO free list in a link RAM.
// Depends on fbpa_pkg and fbpa_ram.
//
// Usage: requests arrive on the s_ stream, one item per request, with the mode
// in s_tuser and the block index (free only) in s_tdata. Each request gives
// exactly one result item on the m_ stream: status in m_tuser, and the granted
// index, byte offset and free count in m_tdata. block_size and total_blocks
// are written through cfg_we/cfg_index/cfg_data and latched by a set-up.
// Free, tear-down and every rejected request take one cycle; an allocate takes
// two, as the next link has to be read from the link RAM before the head moves.
// A successful set-up writes one link entry per cycle, so it keeps s_tready
// low for total_blocks cycles after its item is accepted; its result is
// already presented meanwhile. One request is in work at a time.
// A new item is taken only while the result register is empty or being
// emptied in the same cycle, so a stalled receiver stalls the input side.
// Reset leaves no pool set up (head null, free count zero) and the
// configuration registers at 16 bytes and 256 blocks; the link RAM is not
// cleared, as a set-up writes every entry it will use.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] block_index
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] granted_index, [31:8] byte_offset,
                                 // [40:32] free_count, [47:41] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int PW = IW + 1;
  localparam int XW = (PW > TOTAL_BLOCKS_W) ? PW : TOTAL_BLOCKS_W;
  localparam int MW = (PW + BLOCK_SIZE_W > OFFSET_W) ? PW + BLOCK_SIZE_W : OFFSET_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(NUM_BLOCKS);
  localparam logic [XW-1:0] NUM_X    = XW'(NUM_BLOCKS);

  state_t state, state_next;

  logic [BLOCK_SIZE_W-1:0]   block_size;
  logic [TOTAL_BLOCKS_W-1:0] total_blocks;

  logic [PW-1:0]           head, head_next;
  logic [PW-1:0]           free_blocks, free_next;
  logic [BLOCK_SIZE_W-1:0] active_size, size_next;
  logic [PW-1:0]           active_total, total_next;
  logic [IW-1:0]           cnt, cnt_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic                accept;
  logic                out_load;
  status_t             out_status;
  logic [INDEX_W-1:0]  out_index;
  logic [OFFSET_W-1:0] out_offset;
  logic [PW-1:0]       out_free;

  logic [XW-1:0] idx_x;
  logic [XW-1:0] cfg_total_x;
  logic [XW-1:0] head_x;
  logic [PW-1:0] cnt_succ;
  logic [MW-1:0] product;

  function automatic logic [TOTAL_BLOCKS_W-1:0] out_free_9(input logic [PW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[TOTAL_BLOCKS_W-1:0];
  endfunction

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign idx_x       = XW'(s_tdata);
  assign cfg_total_x = XW'(total_blocks);
  assign head_x      = XW'(head);
  assign cnt_succ    = PW'(cnt) + PW'(1);
  assign product     = MW'(head) * MW'(active_size);

  fbpa_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    head_next  = head;
    free_next  = free_blocks;
    size_next  = active_size;
    total_next = active_total;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = (cnt_succ == active_total) ? NULL_PTR : cnt_succ;
    ram_raddr  = head[IW-1:0];
    out_load   = 1'b0;
    out_status = STAT_OK;
    out_index  = '0;
    out_offset = '0;
    out_free   = free_blocks;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (mode_t'(s_tuser))
            MODE_SETUP: begin
              if (block_size == '0 || total_blocks == '0 || cfg_total_x > NUM_X) begin
                out_status = STAT_NO_POOL;
              end else begin
                size_next  = block_size;
                total_next = cfg_total_x[PW-1:0];
                free_next  = cfg_total_x[PW-1:0];
                head_next  = '0;
                cnt_next   = '0;
                out_free   = cfg_total_x[PW-1:0];
                state_next = ST_SWEEP;
              end
            end
            MODE_ALLOC: begin
              if (active_total == '0) begin
                out_status = STAT_NO_POOL;
              end else if (head >= NULL_PTR || free_blocks == '0) begin
                out_status = STAT_EMPTY;
              end else begin
                // The result is produced once the next link comes back.
                out_load   = 1'b0;
                state_next = ST_POP;
              end
            end
            MODE_FREE: begin
              if (active_total == '0) begin
                out_status = STAT_NO_POOL;
              end else if (idx_x >= XW'(active_total)) begin
                out_status = STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = idx_x[IW-1:0];
                ram_wdata = head;
                head_next = idx_x[PW-1:0];
                if (free_blocks != NULL_PTR) begin
                  free_next = free_blocks + PW'(1);
                end
                out_free = free_next;
              end
            end
            MODE_TEARDOWN: begin
              if (head >= NULL_PTR) begin
                out_status = STAT_NO_POOL;
              end else begin
                size_next  = '0;
                total_next = '0;
                free_next  = '0;
                head_next  = NULL_PTR;
                out_free   = '0;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        out_load   = 1'b1;
        out_index  = head_x[INDEX_W-1:0];
        out_offset = product[OFFSET_W-1:0];
        head_next  = ram_rdata;
        free_next  = free_blocks - PW'(1);
        out_free   = free_next;
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        // Link block cnt to its successor, the last one to the null marker.
        ram_we   = 1'b1;
        cnt_next = cnt_succ[IW-1:0];
        if (cnt_succ == active_total) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= NULL_PTR;
      free_blocks  <= '0;
      active_size  <= '0;
      active_total <= '0;
      cnt          <= '0;
      block_size   <= BLOCK_SIZE_RST;
      total_blocks <= TOTAL_BLOCKS_RST;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      free_blocks  <= free_next;
      active_size  <= size_next;
      active_total <= total_next;
      cnt          <= cnt_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_SIZE:   block_size   <= cfg_data;
          CFG_TOTAL_BLOCKS: total_blocks <= cfg_data[TOTAL_BLOCKS_W-1:0];
          default:          ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= {7'd0, out_free_9(out_free), out_offset, out_index};
    end
  end

  // A result is never loaded over one that the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load && m_tvalid |-> m_tready)
    else $error("result register overwritten while still pending");

  // The free count never runs past the pool depth.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= NULL_PTR)
    else $error("free count beyond pool depth");

  // Without a pool the list is empty and nothing is counted free.
  a_no_pool_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && active_total == '0 |-> head == NULL_PTR && free_blocks == '0)
    else $error("list not empty without a pool");

  // The set-up sweep stays inside the configured pool.
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> PW'(cnt) < active_total)
    else $error("set-up sweep beyond pool size");

  // A popped link is either the null marker or a block of the current pool.
  a_link_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |-> ram_rdata == NULL_PTR || ram_rdata < active_total)
    else $error("link table holds a block outside the pool");

endmodule

[dv/fixed_block_pool_allocator_test.sv]
// Self-checking testbench for fixed_block_pool_allocator: directed and random
// pool requests against a free-list predictor, with random stalls on both streams.
// Depends on fbpa_pkg and the allocator RTL.
module fixed_block_pool_allocator_test
  import fbpa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH = 256;
  localparam logic [TOTAL_BLOCKS_W-1:0] NULL_LINK = 9'd256;
  // A set-up keeps the block busy after its item while it writes a link entry for each pool block.
  localparam int SWEEP_WAIT = POOL_DEPTH + 44;

  typedef struct packed {
    mode_t              mode;
    logic [INDEX_W-1:0] index;
  } request_t;

  typedef struct packed {
    status_t                   status;
    logic [INDEX_W-1:0]        granted;
    logic [OFFSET_W-1:0]       offset;
    logic [TOTAL_BLOCKS_W-1:0] free_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] block_index
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [7:0] granted_index, [31:8] byte_offset,
                               // [40:32] free_count, [47:41] zero
  logic [1:0]  m_tuser;        // [1:0] status
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fixed_block_pool_allocator #(
    .NUM_BLOCKS(POOL_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: the free list and the latched pool settings.
  logic [TOTAL_BLOCKS_W-1:0] link_mem [POOL_DEPTH];
  logic [TOTAL_BLOCKS_W-1:0] head = NULL_LINK;
  logic [TOTAL_BLOCKS_W-1:0] free_n = '0;
  logic [BLOCK_SIZE_W-1:0]   act_size = '0;
  logic [TOTAL_BLOCKS_W-1:0] act_total = '0;
  logic [BLOCK_SIZE_W-1:0]   cfg_size = BLOCK_SIZE_RST;
  logic [TOTAL_BLOCKS_W-1:0] cfg_total = TOTAL_BLOCKS_RST;

  request_t           request_queue [$];
  reply_t             replies_due [$];
  logic [INDEX_W-1:0] blocks_out [$];   // blocks granted and not yet returned
  int                 queued_n = 0;
  int                 accepted_n = 0;
  int                 fault_count = 0;

  logic     req_fire = 1'b0;
  logic     res_fire = 1'b0;
  int       req_gap = 0;
  int       res_gap = 0;
  int       res_draw;
  logic     src_steady = 1'b0;
  logic     snk_steady = 1'b0;
  request_t drv_item;
  request_t mon_req;
  reply_t   mon_reply;

  function automatic reply_t serve_request(request_t rq);
    reply_t                    rp;
    logic [TOTAL_BLOCKS_W-1:0] blk;
    rp = '0;
    rp.status = STAT_OK;
    case (rq.mode)
      MODE_SETUP: begin
        if (cfg_size == 0 || cfg_total == 0 || cfg_total > POOL_DEPTH) begin
          rp.status = STAT_NO_POOL;
        end else begin
          act_size = cfg_size;
          act_total = cfg_total;
          free_n = cfg_total;
          for (int i = 0; i < POOL_DEPTH; i++) begin
            if (i < cfg_total) begin
              link_mem[i] = (i + 1 < cfg_total) ? TOTAL_BLOCKS_W'(i + 1) : NULL_LINK;
            end
          end
          head = '0;
        end
      end
      MODE_ALLOC: begin
        if (act_total == 0) begin
          rp.status = STAT_NO_POOL;
        end else if (head >= POOL_DEPTH || free_n == 0) begin
          rp.status = STAT_EMPTY;
        end else begin
          blk = head;
          head = link_mem[blk[INDEX_W-1:0]];
          free_n = free_n - 1'b1;
          rp.granted = blk[INDEX_W-1:0];
          rp.offset = blk[INDEX_W-1:0] * act_size;
        end
      end
      MODE_FREE: begin
        if (act_total == 0) begin
          rp.status = STAT_NO_POOL;
        end else if ({1'b0, rq.index} >= act_total) begin
          rp.status = STAT_RANGE;
        end else begin
          // Returning a block that is already free is not caught: it is pushed again.
          link_mem[rq.index] = head;
          head = {1'b0, rq.index};
          if (free_n < POOL_DEPTH) free_n = free_n + 1'b1;
        end
      end
      default: begin
        // A pool whose blocks are all handed out has a null head and cannot be torn down.
        if (head >= POOL_DEPTH) begin
          rp.status = STAT_NO_POOL;
        end else begin
          act_size = '0;
          act_total = '0;
          free_n = '0;
          head = NULL_LINK;
        end
      end
    endcase
    rp.free_count = free_n;
    return rp;
  endfunction

  task automatic check_reply(reply_t want);
    if (m_tuser !== want.status) begin
      $display("%0t status: expected %0d, actual %0d", $time, want.status, m_tuser);
      fault_count++;
    end
    if (m_tdata[7:0] !== want.granted) begin
      $display("%0t granted_index: expected %0d, actual %0d", $time, want.granted,
               m_tdata[7:0]);
      fault_count++;
    end
    if (m_tdata[31:8] !== want.offset) begin
      $display("%0t byte_offset: expected %h, actual %h", $time, want.offset,
               m_tdata[31:8]);
      fault_count++;
    end
    if (m_tdata[40:32] !== want.free_count) begin
      $display("%0t free_count: expected %0d, actual %0d", $time, want.free_count,
               m_tdata[40:32]);
      fault_count++;
    end
    if (m_tdata[47:41] !== 7'd0) begin
      $display("%0t tdata padding: expected 0, actual %h", $time, m_tdata[47:41]);
      fault_count++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Request driver: presents queued items at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      req_gap <= 0;
    end else if (s_tvalid && !req_fire) begin
      // Item still waiting for s_tready.
    end else if (req_gap != 0) begin
      s_tvalid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (request_queue.size() != 0) begin
      drv_item = request_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= drv_item.index;
      s_tuser <= drv_item.mode;
      req_gap <= src_steady ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) src_steady <= !src_steady;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result receiver: after each item it may hold m_tready low for a random stall, never in steady phases.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      res_gap <= 0;
    end else if (m_tready) begin
      if (res_fire) begin
        res_draw = snk_steady ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) snk_steady <= !snk_steady;
        if (res_draw != 0) begin
          m_tready <= 1'b0;
          res_gap <= res_draw - 1;
        end
      end
    end else if (res_gap == 0) begin
      m_tready <= 1'b1;
    end else begin
      res_gap <= res_gap - 1;
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
      res_fire <= 1'b0;
    end else begin
      req_fire <= s_tvalid && s_tready;
      res_fire <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0d tdata %h",
                   $time, m_tuser, m_tdata);
          fault_count++;
        end else begin
          check_reply(replies_due.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        mon_req.mode = mode_t'(s_tuser);
        mon_req.index = s_tdata;
        mon_reply = serve_request(mon_req);
        replies_due.push_back(mon_reply);
        accepted_n++;
        if (mon_req.mode == MODE_ALLOC && mon_reply.status == STAT_OK) begin
          blocks_out.push_back(mon_reply.granted);
        end else if ((mon_req.mode == MODE_SETUP || mon_req.mode == MODE_TEARDOWN) &&
                     mon_reply.status == STAT_OK) begin
          blocks_out.delete();
        end
      end
    end
  end

  task automatic send(mode_t m, logic [INDEX_W-1:0] idx);
    request_t rq;
    rq.mode = m;
    rq.index = idx;
    while (request_queue.size() > 2) @(negedge clk);
    request_queue.push_back(rq);
    queued_n++;
  endtask

  // Wait until every item has been taken and answered, then let a set-up sweep finish.
  task automatic settle();
    while (accepted_n != queued_n || replies_due.size() != 0) @(negedge clk);
    repeat (SWEEP_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    if (sel == CFG_BLOCK_SIZE) cfg_size = value;
    else cfg_total = value[TOTAL_BLOCKS_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pool(logic [15:0] size_val, logic [15:0] total_val);
    settle();
    write_reg(CFG_BLOCK_SIZE, size_val);
    write_reg(CFG_TOTAL_BLOCKS, total_val);
  endtask

  initial begin : stimulus
    int          r;
    int          k;
    logic [15:0] bsz;
    logic [15:0] tot;
    logic [7:0]  idx;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Requests before any pool exists, then the reset settings of 16 bytes and 256 blocks.
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_FREE, 8'd5);
    send(MODE_TEARDOWN, 8'($urandom));
    send(MODE_SETUP, 8'($urandom));
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_FREE, 8'd255);
    send(MODE_FREE, 8'd255);
    send(MODE_FREE, 8'd7);      // free count already at its ceiling
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_SETUP, 8'($urandom));
    send(MODE_TEARDOWN, 8'($urandom));

    // One-block pool: exhaust it, then try to tear it down with every block out.
    set_pool(16'hFFFF, 16'd1);
    send(MODE_SETUP, 8'($urandom));
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_ALLOC, 8'($urandom));
    send(MODE_TEARDOWN, 8'($urandom));
    send(MODE_FREE, 8'd1);
    send(MODE_FREE, 8'd0);
    send(MODE_TEARDOWN, 8'($urandom));

    // Settings that a set-up must reject.
    set_pool(16'd0, 16'd256);
    send(MODE_SETUP, 8'($urandom));
    set_pool(16'hFFFF, 16'd0);
    send(MODE_SETUP, 8'($urandom));
    set_pool(16'hFFFF, {7'h55, 9'd300});
    send(MODE_SETUP, 8'($urandom));

    // Largest offset: last block at the largest block size.
    set_pool(16'hFFFF, 16'd256);
    send(MODE_SETUP, 8'($urandom));
    send(MODE_FREE, 8'd255);
    send(MODE_ALLOC, 8'($urandom));

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        0:       bsz = 16'd0;
        1, 2:    bsz = 16'd1;
        3:       bsz = 16'hFFFF;
        default: bsz = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 9))
        0:       tot = 16'd1;
        1:       tot = 16'd2;
        2:       tot = 16'd256;
        3:       tot = 16'd0;
        4:       tot = 16'($urandom_range(257, 511));
        5, 6:    tot = 16'($urandom_range(1, 256));
        default: tot = 16'($urandom_range(3, 24));
      endcase
      tot[15:9] = 7'($urandom);
      set_pool(bsz, tot);
      send(MODE_SETUP, 8'($urandom));
      for (int n = 0; n < 68; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send(MODE_ALLOC, 8'($urandom));
        end else if (r < 85) begin
          // Return a block that is out if any; else one in the configured range, if that is valid.
          if (blocks_out.size() != 0) begin
            k = $urandom_range(0, blocks_out.size() - 1);
            idx = blocks_out[k];
            blocks_out.delete(k);
          end else if (cfg_total != 0 && cfg_total <= POOL_DEPTH) begin
            idx = 8'($urandom_range(0, cfg_total - 1));
          end else begin
            idx = 8'($urandom);
          end
          send(MODE_FREE, idx);
        end else if (r < 92) begin
          send(MODE_FREE, 8'($urandom));
        end else if (r < 96) begin
          send(MODE_TEARDOWN, 8'($urandom));
        end else begin
          send(MODE_SETUP, 8'($urandom));
        end
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fixed_block_pool_allocator.sv
dv/fixed_block_pool_allocator_test.sv
